// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

    localparam int WIN_DEPTH = 4;
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int FQ_DEPTH  = 2;
    localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 4;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);
    localparam int DIR_COUNT = 12;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [8:0] LA_NONE  = 9'h100;

    localparam logic [1:0] KIND_WS  = 2'd0;
    localparam logic [1:0] KIND_LEX = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_ERR = 2'd3;

    localparam logic [1:0] ERR_COMMENT = 2'd0;
    localparam logic [1:0] ERR_HEADER  = 2'd1;
    localparam logic [1:0] ERR_CHAR    = 2'd2;
    localparam logic [1:0] ERR_STRING  = 2'd3;

    localparam logic [6:0] CL_EOF      = 7'd0;
    localparam logic [6:0] CL_HEADER   = 7'd1;
    localparam logic [6:0] CL_IDENT    = 7'd2;
    localparam logic [6:0] CL_NUMBER   = 7'd3;
    localparam logic [6:0] CL_CHAR     = 7'd4;
    localparam logic [6:0] CL_STRING   = 7'd5;
    localparam logic [6:0] CL_HASH     = 7'd27;
    localparam logic [6:0] CL_HASHHASH = 7'd50;
    localparam logic [6:0] CL_OTHER    = 7'd54;
    localparam logic [6:0] CL_DIR0     = 7'd55;
    localparam logic [6:0] CL_INCLUDE  = 7'd61;

    localparam logic [2:0] IDLEN_MAX = 3'd7;

    localparam logic [2:0] DIR_LEN [DIR_COUNT] = '{
        3'd2, 3'd5, 3'd6, 3'd4, 3'd4, 3'd5, 3'd7, 3'd6, 3'd5, 3'd4, 3'd5, 3'd6
    };
    localparam logic [55:0] DIR_NAME [DIR_COUNT] = '{
        "if", "ifdef", "ifndef", "elif", "else", "endif",
        "include", "define", "undef", "line", "error", "pragma"
    };

    typedef enum logic [8:0] {
        MODE_IDLE  = 9'b000000001,
        MODE_WS    = 9'b000000010,
        MODE_LINE  = 9'b000000100,
        MODE_BLOCK = 9'b000001000,
        MODE_IDENT = 9'b000010000,
        MODE_NUM   = 9'b000100000,
        MODE_CHAR  = 9'b001000000,
        MODE_STR   = 9'b010000000,
        MODE_HDR   = 9'b100000000
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_ws;
        logic       is_alpha;
        logic       is_digit;
        logic       is_idch;
    } elem_t;

    typedef struct packed {
        elem_t elem;
        logic  eos;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [6:0] cls;
        logic       nl;
        logic [1:0] err;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    v0;
        result_t d0;
        logic    v1;
        result_t d1;
    } oq_wr_t;

    typedef struct packed {
        logic [2:0] len;
        logic [6:0] cls;
    } punct_t;

    function automatic elem_t classify(input logic [7:0] ch);
        elem_t e;
        e.ch       = ch;
        e.is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL);
        e.is_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
        e.is_digit = (ch >= "0" && ch <= "9");
        e.is_idch  = e.is_alpha || e.is_digit || (ch == "_");
        return e;
    endfunction

    function automatic logic eq(input logic [8:0] x, input logic [7:0] ch);
        return x == {1'b0, ch};
    endfunction

    // Character of a directive name at a position, zero past its end.
    function automatic logic [7:0] dir_char(input int i, input logic [2:0] pos);
        int sh;
        sh = 8 * (int'(DIR_LEN[i]) - 1 - int'(pos));
        if (pos < DIR_LEN[i])
            return DIR_NAME[i][sh +: 8];
        return 8'd0;
    endfunction

    function automatic result_t mk_ws(input logic [7:0] ch);
        result_t r;
        r = '0;
        r.kind = KIND_WS;
        r.ch = ch;
        return r;
    endfunction

    function automatic result_t mk_lex(input logic [7:0] ch);
        result_t r;
        r = '0;
        r.kind = KIND_LEX;
        r.ch = ch;
        return r;
    endfunction

    function automatic result_t mk_end(input logic [6:0] cls, input logic nl);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.cls = cls;
        r.nl = nl;
        return r;
    endfunction

    function automatic result_t mk_err(input logic [1:0] code);
        result_t r;
        r = '0;
        r.kind = KIND_ERR;
        r.err = code;
        return r;
    endfunction

    // Longest punctuator at the window front; absent characters never match.
    function automatic punct_t match_punct(input logic [8:0] a, input logic [8:0] b,
                                           input logic [8:0] c, input logic [8:0] d);
        punct_t p;
        p.len = 3'd0;
        p.cls = 7'd0;
        if (!a[8] && !b[8] && !c[8] && !d[8] &&
            {a[7:0], b[7:0], c[7:0], d[7:0]} == "%:%:") begin
            p.len = 3'd4;
            p.cls = CL_HASHHASH;
        end
        if (p.len == 3'd0 && !a[8] && !b[8] && !c[8]) begin
            case ({a[7:0], b[7:0], c[7:0]})
                "<<=": begin p.len = 3'd3; p.cls = 7'd51; end
                ">>=": begin p.len = 3'd3; p.cls = 7'd52; end
                "...": begin p.len = 3'd3; p.cls = 7'd53; end
                default: ;
            endcase
        end
        if (p.len == 3'd0 && !a[8] && !b[8]) begin
            p.len = 3'd2;
            case ({a[7:0], b[7:0]})
                "->": p.cls = 7'd31;
                "++": p.cls = 7'd32;
                "--": p.cls = 7'd33;
                "<<": p.cls = 7'd34;
                ">>": p.cls = 7'd35;
                "<=": p.cls = 7'd36;
                ">=": p.cls = 7'd37;
                "==": p.cls = 7'd38;
                "!=": p.cls = 7'd39;
                "&&": p.cls = 7'd40;
                "||": p.cls = 7'd41;
                "*=": p.cls = 7'd42;
                "/=": p.cls = 7'd43;
                "%=": p.cls = 7'd44;
                "+=": p.cls = 7'd45;
                "-=": p.cls = 7'd46;
                "&=": p.cls = 7'd47;
                "^=": p.cls = 7'd48;
                "|=": p.cls = 7'd49;
                "##": p.cls = 7'd50;
                "<:": p.cls = 7'd8;
                ":>": p.cls = 7'd9;
                "<%": p.cls = 7'd10;
                "%>": p.cls = 7'd11;
                "%:": p.cls = CL_HASH;
                default: p.len = 3'd0;
            endcase
        end
        if (p.len == 3'd0 && !a[8]) begin
            p.len = 3'd1;
            case (a[7:0])
                "(": p.cls = 7'd6;
                ")": p.cls = 7'd7;
                "[": p.cls = 7'd8;
                "]": p.cls = 7'd9;
                "{": p.cls = 7'd10;
                "}": p.cls = 7'd11;
                ".": p.cls = 7'd12;
                "&": p.cls = 7'd13;
                "*": p.cls = 7'd14;
                "+": p.cls = 7'd15;
                "-": p.cls = 7'd16;
                "~": p.cls = 7'd17;
                "!": p.cls = 7'd18;
                "/": p.cls = 7'd19;
                "%": p.cls = 7'd20;
                "<": p.cls = 7'd21;
                ">": p.cls = 7'd22;
                "^": p.cls = 7'd23;
                "|": p.cls = 7'd24;
                "=": p.cls = 7'd25;
                ",": p.cls = 7'd26;
                "#": p.cls = CL_HASH;
                "?": p.cls = 7'd28;
                ":": p.cls = 7'd29;
                ";": p.cls = 7'd30;
                default: p.len = 3'd0;
            endcase
        end
        return p;
    endfunction

endpackage

// ===== rtl/cpt_in_if.sv =====
interface cpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       end_of_source;

    modport source (output valid, output src_byte, output end_of_source, input ready);
    modport sink (input valid, input src_byte, input end_of_source, output ready);
endinterface

// ===== rtl/cpt_out_if.sv =====
interface cpt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] item_kind;
    logic [7:0] char_out;
    logic [6:0] token_class;
    logic       newline_before;
    logic [1:0] error_code;
    logic       last_of_run;

    modport source (output valid, output item_kind, output char_out, output token_class,
                    output newline_before, output error_code, output last_of_run,
                    input ready);
    modport sink (input valid, input item_kind, input char_out, input token_class,
                  input newline_before, input error_code, input last_of_run,
                  output ready);
endinterface

// ===== rtl/cpt_front.sv =====
module cpt_front (
    input  logic              clk,
    input  logic              rst_n,
    cpt_in_if.sink            chars,
    output logic              fq_valid,
    output cpt_pkg::in_item_t fq_item,
    input  logic              fq_ready
);
    import cpt_pkg::*;

    in_item_t              q_reg [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]   wr_reg, wr_next;
    logic [FQ_PTR_W-1:0]   rd_reg, rd_next;
    logic [FQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  push;
    logic                  pop;

    assign chars.ready = (cnt_reg != FQ_CNT_W'(FQ_DEPTH));
    assign push        = chars.valid && chars.ready;
    assign fq_valid    = (cnt_reg != '0);
    assign fq_item     = q_reg[rd_reg];
    assign pop         = fq_valid && fq_ready;

    always_comb
    begin
        wr_next  = wr_reg + FQ_PTR_W'(push);
        rd_next  = rd_reg + FQ_PTR_W'(pop);
        cnt_next = cnt_reg + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
    end

    // Characters are classified on the way in so the back end only compares.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg].elem <= classify(chars.src_byte);
            q_reg[wr_reg].eos  <= chars.end_of_source;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/cpt_out_q.sv =====
module cpt_out_q (
    input  logic            clk,
    input  logic            rst_n,
    input  cpt_pkg::oq_wr_t wr,
    output logic            room,
    cpt_out_if.source       tokens
);
    import cpt_pkg::*;

    result_t               mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_reg, wr_next;
    logic [OQ_PTR_W-1:0]   rd_reg, rd_next;
    logic [OQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  pop;
    result_t               head;

    assign head                  = mem_reg[rd_reg];
    assign tokens.valid          = (cnt_reg != '0);
    assign tokens.item_kind      = head.kind;
    assign tokens.char_out       = head.ch;
    assign tokens.token_class    = head.cls;
    assign tokens.newline_before = head.nl;
    assign tokens.error_code     = head.err;
    assign tokens.last_of_run    = head.last;
    assign pop                   = tokens.valid && tokens.ready;

    // The back end may write two entries in one cycle.
    assign room = (cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + OQ_PTR_W'(wr.v0) + OQ_PTR_W'(wr.v1);
        rd_next  = rd_reg + OQ_PTR_W'(pop);
        cnt_next = cnt_reg + OQ_CNT_W'(wr.v0) + OQ_CNT_W'(wr.v1) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr.v0)
        begin
            mem_reg[wr_reg] <= wr.d0;
        end
        if (wr.v1)
        begin
            mem_reg[wr_reg + OQ_PTR_W'(1)] <= wr.d1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/cpt_back.sv =====
module cpt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fq_valid,
    input  cpt_pkg::in_item_t fq_item,
    output logic              fq_ready,
    input  logic              oq_room,
    output cpt_pkg::oq_wr_t   oq_wr
);
    import cpt_pkg::*;

    elem_t                win_reg [WIN_DEPTH];
    elem_t                win_next [WIN_DEPTH];
    logic [FILL_W-1:0]    fill_reg, fill_next;
    mode_t                mode_reg, mode_next;
    logic                 nl_reg, nl_next;
    logic                 dexp_reg, dexp_next;
    logic                 hexp_reg, hexp_next;
    logic                 hca_reg, hca_next;
    logic [DIR_COUNT-1:0] cand_reg, cand_next;
    logic [2:0]           idlen_reg, idlen_next;
    logic                 err_reg, err_next;
    logic                 drain_reg, drain_next;
    logic [1:0]           pcnt_reg, pcnt_next;
    logic                 pend_reg, pend_next;
    logic [6:0]           pcls_reg, pcls_next;
    logic                 held_v_reg, held_v_next;
    result_t              held_reg, held_next;

    logic [8:0]           la9 [WIN_DEPTH];
    elem_t                c_el;
    logic [8:0]           n9;
    punct_t               punct;
    logic                 need_step;
    logic                 step_go;
    logic [1:0]           k;
    logic                 e_v;
    result_t              e;
    logic                 fail_now;
    logic [1:0]           fail_code;
    logic                 do_end;
    logic [6:0]           end_in;
    logic [6:0]           res_cls;
    logic                 found;
    logic                 clear_now;
    logic                 run_end;
    logic [FILL_W-1:0]    fill_after;
    logic                 acc;
    logic [7:0]           q_ch;
    logic [7:0]           d_ch;
    logic                 is_str;

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            la9[i] = (FILL_W'(i) < fill_reg) ? {1'b0, win_reg[i].ch} : LA_NONE;
        end
    end

    assign c_el  = win_reg[0];
    assign n9    = la9[1];
    assign punct = match_punct(la9[0], la9[1], la9[2], la9[3]);

    // A step is due while a token is being spelled out, while the window is full,
    // or while the stream is being drained after its end.
    assign need_step = !err_reg &&
                       ((pcnt_reg != 2'd0) || pend_reg || drain_reg ||
                        (fill_reg == FILL_W'(WIN_DEPTH)));
    assign step_go   = need_step && oq_room;

    always_comb
    begin
        win_next    = win_reg;
        fill_next   = fill_reg;
        mode_next   = mode_reg;
        nl_next     = nl_reg;
        dexp_next   = dexp_reg;
        hexp_next   = hexp_reg;
        hca_next    = hca_reg;
        cand_next   = cand_reg;
        idlen_next  = idlen_reg;
        err_next    = err_reg;
        drain_next  = drain_reg;
        pcnt_next   = pcnt_reg;
        pend_next   = pend_reg;
        pcls_next   = pcls_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        k           = 2'd0;
        e_v         = 1'b0;
        e           = '0;
        fail_now    = 1'b0;
        fail_code   = ERR_COMMENT;
        do_end      = 1'b0;
        end_in      = CL_EOF;
        res_cls     = CL_EOF;
        found       = 1'b0;
        clear_now   = 1'b0;
        run_end     = 1'b0;
        oq_wr       = '0;
        fq_ready    = 1'b0;
        acc         = 1'b0;
        is_str      = (mode_reg == MODE_STR);
        q_ch        = is_str ? "\"" : "'";
        d_ch        = hca_reg ? ">" : "\"";

        if (step_go)
        begin
            if (pcnt_reg != 2'd0)
            begin
                e_v = 1'b1;
                e = mk_lex(c_el.ch);
                k = 2'd1;
                pcnt_next = pcnt_reg - 2'd1;
            end
            else if (pend_reg)
            begin
                do_end = 1'b1;
                end_in = pcls_reg;
                pend_next = 1'b0;
            end
            else if (fill_reg == '0)
            begin
                // Window drained after the end of the stream: close what is open.
                clear_now = 1'b1;
                case (mode_reg)
                    MODE_WS, MODE_LINE:
                    begin
                        do_end = 1'b1;
                        end_in = CL_EOF;
                    end
                    MODE_BLOCK:
                    begin
                        fail_now = 1'b1;
                        fail_code = ERR_COMMENT;
                    end
                    MODE_IDENT:
                    begin
                        do_end = 1'b1;
                        end_in = CL_IDENT;
                    end
                    MODE_NUM:
                    begin
                        do_end = 1'b1;
                        end_in = CL_NUMBER;
                    end
                    MODE_CHAR:
                    begin
                        fail_now = 1'b1;
                        fail_code = ERR_CHAR;
                    end
                    MODE_STR:
                    begin
                        fail_now = 1'b1;
                        fail_code = ERR_STRING;
                    end
                    MODE_HDR:
                    begin
                        fail_now = 1'b1;
                        fail_code = ERR_HEADER;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (mode_reg)
                    MODE_LINE:
                    begin
                        if (c_el.ch == CH_NL)
                        begin
                            e_v = 1'b1;
                            e = mk_ws(CH_NL);
                            nl_next = 1'b1;
                            mode_next = MODE_WS;
                        end
                        k = 2'd1;
                    end
                    MODE_BLOCK:
                    begin
                        if (c_el.ch == "*" && eq(n9, "/"))
                        begin
                            k = 2'd2;
                            mode_next = MODE_WS;
                        end
                        else
                        begin
                            k = 2'd1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (c_el.is_idch)
                        begin
                            for (int i = 0; i < DIR_COUNT; i++)
                            begin
                                if (dir_char(i, idlen_reg) != c_el.ch)
                                begin
                                    cand_next[i] = 1'b0;
                                end
                            end
                            if (idlen_reg != IDLEN_MAX)
                            begin
                                idlen_next = idlen_reg + 3'd1;
                            end
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                        end
                        else
                        begin
                            do_end = 1'b1;
                            end_in = CL_IDENT;
                        end
                    end
                    MODE_NUM:
                    begin
                        if (c_el.is_idch || c_el.ch == ".")
                        begin
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            // An exponent letter takes its sign along.
                            if ((c_el.ch == "e" || c_el.ch == "E" ||
                                 c_el.ch == "p" || c_el.ch == "P") &&
                                (eq(n9, "+") || eq(n9, "-")))
                            begin
                                pcnt_next = 2'd1;
                            end
                        end
                        else
                        begin
                            do_end = 1'b1;
                            end_in = CL_NUMBER;
                        end
                    end
                    MODE_CHAR, MODE_STR:
                    begin
                        if (c_el.ch == CH_NL)
                        begin
                            fail_now = 1'b1;
                            fail_code = is_str ? ERR_STRING : ERR_CHAR;
                        end
                        else
                        begin
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            if (c_el.ch == q_ch)
                            begin
                                pend_next = 1'b1;
                                pcls_next = is_str ? CL_STRING : CL_CHAR;
                            end
                            else if (c_el.ch == "\\" && (eq(n9, q_ch) || eq(n9, "\\")))
                            begin
                                pcnt_next = 2'd1;
                            end
                        end
                    end
                    MODE_HDR:
                    begin
                        if (c_el.ch != d_ch && c_el.ch == CH_NL)
                        begin
                            fail_now = 1'b1;
                            fail_code = ERR_HEADER;
                        end
                        else
                        begin
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            if (c_el.ch == d_ch)
                            begin
                                pend_next = 1'b1;
                                pcls_next = CL_HEADER;
                            end
                        end
                    end
                    default:
                    begin
                        if (c_el.is_ws)
                        begin
                            if (c_el.ch == CH_NL)
                            begin
                                nl_next = 1'b1;
                            end
                            e_v = 1'b1;
                            e = mk_ws(c_el.ch);
                            k = 2'd1;
                            mode_next = MODE_WS;
                        end
                        else if (c_el.ch == "/" && (eq(n9, "/") || eq(n9, "*")))
                        begin
                            // A comment stands for a single space.
                            e_v = 1'b1;
                            e = mk_ws(CH_SPACE);
                            k = 2'd2;
                            mode_next = eq(n9, "/") ? MODE_LINE : MODE_BLOCK;
                        end
                        else if (hexp_reg && (c_el.ch == "\"" || c_el.ch == "<"))
                        begin
                            hca_next = (c_el.ch == "<");
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            mode_next = MODE_HDR;
                        end
                        else if ((c_el.is_alpha &&
                                  !(c_el.ch == "L" && (eq(n9, "\"") || eq(n9, "'")))) ||
                                 c_el.ch == "_")
                        begin
                            cand_next = '1;
                            idlen_next = '0;
                            mode_next = MODE_IDENT;
                        end
                        else if (c_el.is_digit || (c_el.ch == "." && n9[8] == 1'b0 &&
                                 win_reg[1].is_digit))
                        begin
                            mode_next = MODE_NUM;
                        end
                        else if (c_el.ch == "'" || c_el.ch == "\"")
                        begin
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            mode_next = (c_el.ch == "\"") ? MODE_STR : MODE_CHAR;
                        end
                        else if (c_el.ch == "L")
                        begin
                            // Wide literal: the quote follows as a second lexeme character.
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            pcnt_next = 2'd1;
                            mode_next = eq(n9, "\"") ? MODE_STR : MODE_CHAR;
                        end
                        else
                        begin
                            e_v = 1'b1;
                            e = mk_lex(c_el.ch);
                            k = 2'd1;
                            pend_next = 1'b1;
                            if (punct.len != 3'd0)
                            begin
                                pcnt_next = 2'(punct.len - 3'd1);
                                pcls_next = punct.cls;
                            end
                            else
                            begin
                                pcls_next = CL_OTHER;
                            end
                        end
                    end
                endcase
            end

            if (do_end)
            begin
                res_cls = end_in;
                if (dexp_reg)
                begin
                    if (end_in == CL_IDENT && !nl_reg)
                    begin
                        for (int i = 0; i < DIR_COUNT; i++)
                        begin
                            if (!found && cand_reg[i] && DIR_LEN[i] == idlen_reg)
                            begin
                                res_cls = CL_DIR0 + 7'(i);
                                found = 1'b1;
                            end
                        end
                    end
                    dexp_next = 1'b0;
                end
                hexp_next = (res_cls == CL_INCLUDE);
                if (res_cls == CL_HASH && nl_reg)
                begin
                    dexp_next = 1'b1;
                end
                e_v = 1'b1;
                e = mk_end(res_cls, nl_reg);
                nl_next = 1'b0;
                mode_next = MODE_IDLE;
            end

            if (fail_now)
            begin
                e_v = 1'b1;
                e = mk_err(fail_code);
                err_next = 1'b1;
            end
        end

        fill_after = fill_reg - FILL_W'(k);

        if (step_go)
        begin
            run_end = fail_now || clear_now ||
                      (!drain_reg && pcnt_next == 2'd0 && !pend_next &&
                       fill_after < FILL_W'(WIN_DEPTH));

            // The newest result waits in the holding register until it is known
            // whether it closes the transfer's run of results.
            if (e_v && !run_end)
            begin
                if (held_v_reg)
                begin
                    oq_wr.v0 = 1'b1;
                    oq_wr.d0 = held_reg;
                end
                held_v_next = 1'b1;
                held_next = e;
            end
            else if (e_v)
            begin
                if (held_v_reg)
                begin
                    oq_wr.v0 = 1'b1;
                    oq_wr.d0 = held_reg;
                    oq_wr.v1 = 1'b1;
                    oq_wr.d1 = e;
                    oq_wr.d1.last = 1'b1;
                end
                else
                begin
                    oq_wr.v0 = 1'b1;
                    oq_wr.d0 = e;
                    oq_wr.d0.last = 1'b1;
                end
                held_v_next = 1'b0;
            end
            else if (run_end)
            begin
                if (held_v_reg)
                begin
                    oq_wr.v0 = 1'b1;
                    oq_wr.d0 = held_reg;
                    oq_wr.d0.last = 1'b1;
                end
                held_v_next = 1'b0;
            end
        end

        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if (k != 2'd0 && i + int'(k) < WIN_DEPTH)
            begin
                win_next[i] = win_reg[i + int'(k)];
            end
        end
        fill_next = fill_after;

        fq_ready = err_reg || !need_step ||
                   (step_go && run_end && !drain_reg && !fail_now);
        acc = fq_valid && fq_ready;

        if (acc && !err_reg)
        begin
            if (fq_item.eos)
            begin
                drain_next = 1'b1;
            end
            else
            begin
                win_next[fill_after[WIN_IDX_W-1:0]] = fq_item.elem;
                fill_next = fill_after + FILL_W'(1);
            end
        end

        if (clear_now)
        begin
            fill_next  = '0;
            mode_next  = MODE_IDLE;
            nl_next    = 1'b0;
            dexp_next  = 1'b0;
            hexp_next  = 1'b0;
            hca_next   = 1'b0;
            cand_next  = '1;
            idlen_next = '0;
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        held_reg <= held_next;
        pcls_reg <= pcls_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            mode_reg   <= MODE_IDLE;
            nl_reg     <= 1'b0;
            dexp_reg   <= 1'b0;
            hexp_reg   <= 1'b0;
            hca_reg    <= 1'b0;
            cand_reg   <= '1;
            idlen_reg  <= '0;
            err_reg    <= 1'b0;
            drain_reg  <= 1'b0;
            pcnt_reg   <= 2'd0;
            pend_reg   <= 1'b0;
            held_v_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            mode_reg   <= mode_next;
            nl_reg     <= nl_next;
            dexp_reg   <= dexp_next;
            hexp_reg   <= hexp_next;
            hca_reg    <= hca_next;
            cand_reg   <= cand_next;
            idlen_reg  <= idlen_next;
            err_reg    <= err_next;
            drain_reg  <= drain_next;
            pcnt_reg   <= pcnt_next;
            pend_reg   <= pend_next;
            held_v_reg <= held_v_next;
        end
    end

`ifndef SYNTHESIS
    a_drain_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> (fill_reg != FILL_W'(WIN_DEPTH)))
        else $error("window full while draining");

    a_held_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!drain_reg && pcnt_reg == 2'd0 && !pend_reg && fill_reg < FILL_W'(WIN_DEPTH))
        |-> !held_v_reg)
        else $error("result held between runs");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error flag dropped");

    a_pending_present: assert property (@(posedge clk) disable iff (!rst_n)
        (pcnt_reg != 2'd0) |-> (fill_reg >= FILL_W'(pcnt_reg)))
        else $error("pending lexeme characters not in window");
`endif

endmodule

// ===== rtl/c_preprocessing_tokenizer_core.sv =====
// Channel  Direction  Payload
// chars    in         src_byte[7:0], end_of_source
// tokens   out        item_kind[1:0], char_out[7:0], token_class[6:0], newline_before,
//                     error_code[1:0], last_of_run
//
// Plain characters pass at one per cycle once the lookahead window is full, while the
// output queue has room. Starting an identifier or number, ending a token, and each
// extra lexeme character of a punctuator, escape, exponent sign or wide prefix take a
// separate step of the window step unit.
// After rst_n falls the block is empty and ready; no clearing pass is needed.
// A two-entry input queue and a four-entry output queue let either side stall alone.
module c_preprocessing_tokenizer_core (
    input  logic      clk,
    input  logic      rst_n,
    cpt_in_if.sink    chars,
    cpt_out_if.source tokens
);
    import cpt_pkg::*;

    logic     fq_valid;
    in_item_t fq_item;
    logic     fq_ready;
    logic     oq_room;
    oq_wr_t   oq_wr;

    cpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .fq_valid (fq_valid),
        .fq_item  (fq_item),
        .fq_ready (fq_ready)
    );

    cpt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .fq_valid (fq_valid),
        .fq_item  (fq_item),
        .fq_ready (fq_ready),
        .oq_room  (oq_room),
        .oq_wr    (oq_wr)
    );

    cpt_out_q u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (oq_wr),
        .room   (oq_room),
        .tokens (tokens)
    );

endmodule
